>>> rtl/tfn_pkg.sv
// Shared types and constants of the triangle face normal block.
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

    // Bits of one unit-normal magnitude: 0..16384 in Q1.14.
    localparam int K_BITS = 15;
    // The quotient is searched in half steps of Q1.14, so the target is scaled by 2^(2*15).
    localparam int SCALE_SHIFT = 2 * K_BITS;
    // Width of one result component.
    localparam int OUT_WIDTH = 16;
    // Width of the threshold register.
    localparam int THRESH_WIDTH = 16;
    // Threshold after reset.
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd2;
    // One in Q1.14.
    localparam logic signed [OUT_WIDTH-1:0] Q14_ONE = 16'sd16384;
    localparam logic signed [OUT_WIDTH-1:0] Q14_ZERO = 16'sd0;
    // Register stages of one normalizing column: one setup stage, one per quotient bit.
    localparam int DIV_LAT = K_BITS + 1;

    typedef struct packed {
        logic vld;
        logic degen;
        logic neg;
    } t_tag;

endpackage
`default_nettype wire

>>> rtl/tfn_norm_div.sv
// Pipelined digit recurrence: round(n * 16384 / sqrt(s)) for one normal component.
`timescale 1ns / 1ps
`default_nettype none
module tfn_norm_div
    import tfn_pkg::*;
#(
    parameter int SW = 100
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_tag          i_tag,
    input  wire logic [SW-1:0] i_n2,
    input  wire logic [SW-1:0] i_s,
    output t_tag               o_tag,
    output logic [K_BITS-1:0]  o_k
);

    localparam int RW  = SW + SCALE_SHIFT + 4;
    localparam int NST = K_BITS;

    // r_r: n^2*2^30 - (2k-1)^2*s, r_p: (2k-1)*s
    logic signed [RW-1:0] r_r [NST+1];
    logic signed [RW-1:0] r_p [NST+1];
    logic [SW-1:0]        r_s [NST+1];
    logic [K_BITS-1:0]    r_k [NST+1];
    t_tag                 r_tag [NST+1];

    // Setup with k = 0, where (2k-1)^2 = 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else begin
            r_tag[0] <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r[0] <= $signed(RW'(i_n2) << SCALE_SHIFT) - $signed(RW'(i_s));
        r_p[0] <= -$signed(RW'(i_s));
        r_s[0] <= i_s;
        r_k[0] <= '0;
    end

    for (genvar j = 1; j <= NST; j++) begin : g_bit
        localparam int B = NST - j;
        logic signed [RW-1:0] n_delta;
        logic signed [RW-1:0] n_trial;
        logic                 n_take;

        // Growth of (2k-1)^2*s when bit B is set: 2^(B+2)*P + 2^(2B+2)*s.
        always_comb begin
            n_delta = (r_p[j-1] <<< (B + 2)) + $signed(RW'(r_s[j-1]) << (2 * B + 2));
            n_trial = r_r[j-1] - n_delta;
            n_take  = !n_trial[RW-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[j] <= '0;
            end else begin
                r_tag[j] <= r_tag[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_r[j] <= n_take ? n_trial : r_r[j-1];
            r_p[j] <= n_take ? r_p[j-1] + $signed(RW'(r_s[j-1]) << (B + 1)) : r_p[j-1];
            r_s[j] <= r_s[j-1];
            r_k[j] <= r_k[j-1] | (K_BITS'(n_take) << B);
        end
    end

    assign o_tag = r_tag[NST];
    assign o_k   = r_k[NST];

endmodule
`default_nettype wire

>>> rtl/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Flat face normal of one triangle per clock. Corners A, B, C come in as signed
// Q12.12; the block forms B-A and C-A, takes their exact cross product N and,
// when |N| > threshold (units of 2^-24), returns round(N/|N|) in signed Q1.14,
// ties away from zero. Otherwise it returns (0, 1.0, 0) with o_degenerate set.
// An item is taken on every edge with start high; busy never rises, so an item
// may enter in every cycle. Each item leaves as a one-cycle o_valid strobe
// after its registers: six stages for edges, products, cross terms, square
// partials, squares and their sum, sixteen stages of the bit-per-stage
// normalizing recurrence, and the output register. The receiver cannot stall.
// Write the threshold through i_cfg_we / i_cfg_wdata only while no item is
// in flight.
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [THRESH_WIDTH-1:0]       i_cfg_wdata,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_third_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_third_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_third_z,
    output logic                               o_valid,
    output logic signed [OUT_WIDTH-1:0]        o_normal_x,
    output logic signed [OUT_WIDTH-1:0]        o_normal_y,
    output logic signed [OUT_WIDTH-1:0]        o_normal_z,
    output logic                               o_degenerate
);

    // Edge, product, cross magnitude, square and sum widths.
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * EW;
    localparam int MW = PW;
    localparam int H  = (MW + 1) / 2;
    localparam int HI = MW - H;
    localparam int QW = 2 * MW;
    localparam int SW = QW + 2;

    logic [THRESH_WIDTH-1:0] r_thresh;
    logic [5:0]              r_vld;

    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_pa [3];
    logic signed [PW-1:0] r_pb [3];
    logic [MW-1:0]        r_mag [3];
    logic [2:0]           r_neg3, r_neg4, r_neg5, r_neg6;
    logic [2*HI-1:0]      r_hh [3];
    logic [HI+H-1:0]      r_hl [3];
    logic [2*H-1:0]       r_ll [3];
    logic [QW-1:0]        r_n2 [3];
    logic [QW-1:0]        r_n2s [3];
    logic [SW-1:0]        r_s;

    logic [2*THRESH_WIDTH-1:0] n_tsq;
    logic                      n_degen;
    t_tag                      n_tag [3];
    t_tag                      w_tag [3];
    logic [K_BITS-1:0]         w_k [3];
    logic signed [OUT_WIDTH-1:0] n_comp [3];

    // Never hold off an item.
    assign busy = 1'b0;

    // Threshold register and valid line; advance every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            r_vld <= {r_vld[4:0], start};
        end
    end

    // Stages 1 to 6: edges, products, cross terms, square partials, squares, sum.
    always_ff @(posedge i_clk) begin
        r_e1[0] <= EW'(i_second_x) - EW'(i_first_x);
        r_e1[1] <= EW'(i_second_y) - EW'(i_first_y);
        r_e1[2] <= EW'(i_second_z) - EW'(i_first_z);
        r_e2[0] <= EW'(i_third_x) - EW'(i_first_x);
        r_e2[1] <= EW'(i_third_y) - EW'(i_first_y);
        r_e2[2] <= EW'(i_third_z) - EW'(i_first_z);

        r_pa[0] <= PW'(r_e1[1]) * PW'(r_e2[2]);
        r_pb[0] <= PW'(r_e1[2]) * PW'(r_e2[1]);
        r_pa[1] <= PW'(r_e1[2]) * PW'(r_e2[0]);
        r_pb[1] <= PW'(r_e1[0]) * PW'(r_e2[2]);
        r_pa[2] <= PW'(r_e1[0]) * PW'(r_e2[1]);
        r_pb[2] <= PW'(r_e1[1]) * PW'(r_e2[0]);

        r_neg4 <= r_neg3;
        r_neg5 <= r_neg4;
        r_neg6 <= r_neg5;
        r_s    <= SW'(r_n2[0]) + SW'(r_n2[1]) + SW'(r_n2[2]);
    end

    for (genvar i = 0; i < 3; i++) begin : g_comp
        logic signed [PW:0] n_diff;

        assign n_diff = (PW + 1)'(r_pa[i]) - (PW + 1)'(r_pb[i]);

        always_ff @(posedge i_clk) begin
            // Split each magnitude in halves so no multiplier grows past the half width.
            r_neg3[i] <= n_diff[PW];
            r_mag[i]  <= n_diff[PW] ? MW'(-n_diff) : MW'(n_diff);
            r_hh[i]   <= (2 * HI)'(r_mag[i][MW-1:H]) * (2 * HI)'(r_mag[i][MW-1:H]);
            r_hl[i]   <= (HI + H)'(r_mag[i][MW-1:H]) * (HI + H)'(r_mag[i][H-1:0]);
            r_ll[i]   <= (2 * H)'(r_mag[i][H-1:0]) * (2 * H)'(r_mag[i][H-1:0]);
            r_n2[i]   <= (QW'(r_hh[i]) << (2 * H)) + (QW'(r_hl[i]) << (H + 1)) + QW'(r_ll[i]);
            r_n2s[i]  <= r_n2[i];
        end

        assign n_tag[i] = '{vld: r_vld[5], degen: n_degen, neg: r_neg6[i]};

        tfn_norm_div #(
            .SW (SW)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (n_tag[i]),
            .i_n2    (SW'(r_n2s[i])),
            .i_s     (r_s),
            .o_tag   (w_tag[i]),
            .o_k     (w_k[i])
        );

        assign n_comp[i] = w_tag[i].neg ? -$signed(OUT_WIDTH'(w_k[i]))
                                        : $signed(OUT_WIDTH'(w_k[i]));
    end

    // Degenerate when |N|^2 <= T^2; a zero normal always lands here.
    always_comb begin
        n_tsq   = (2 * THRESH_WIDTH)'(r_thresh) * (2 * THRESH_WIDTH)'(r_thresh);
        n_degen = !(r_s > SW'(n_tsq));
    end

    // Output register: drop the quotient for the up vector on degenerate items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_tag[0].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_degenerate <= w_tag[0].degen;
        o_normal_x   <= w_tag[0].degen ? Q14_ZERO : n_comp[0];
        o_normal_y   <= w_tag[0].degen ? Q14_ONE  : n_comp[1];
        o_normal_z   <= w_tag[0].degen ? Q14_ZERO : n_comp[2];
    end

`ifndef SYNTHESIS
    a_degen_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_normal_x == Q14_ZERO && o_normal_y == Q14_ONE
                                    && o_normal_z == Q14_ZERO)
        else $error("degenerate item without up vector");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_x >= -Q14_ONE && o_normal_x <= Q14_ONE
                 && o_normal_y >= -Q14_ONE && o_normal_y <= Q14_ONE
                 && o_normal_z >= -Q14_ONE && o_normal_z <= Q14_ONE)
        else $error("normal component out of range");

    a_unit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> o_normal_x >= 16'sd9000 || o_normal_x <= -16'sd9000
                                  || o_normal_y >= 16'sd9000 || o_normal_y <= -16'sd9000
                                  || o_normal_z >= 16'sd9000 || o_normal_z <= -16'sd9000)
        else $error("normal far shorter than unit length");
`endif

endmodule
`default_nettype wire

>>> verif/triangle_face_normal_tb.sv
// Self-checking testbench for the triangle face normal pipeline.
`timescale 1ns / 1ps

import tfn_pkg::*;

// One triangle as it goes into the block.
typedef struct {
    logic signed [23:0] ax, ay, az;
    logic signed [23:0] bx, by, bz;
    logic signed [23:0] cx, cy, cz;
} t_triangle;

// One face normal as it comes out of the block.
typedef struct {
    logic signed [OUT_WIDTH-1:0] nx, ny, nz;
    logic                        degen;
} t_face_normal;

// Holds the expected face normals in order and checks each strobe against the oldest one.
class normal_scoreboard;
    t_face_normal             expected_q[$];
    logic [THRESH_WIDTH-1:0]  threshold;
    int                       errors;
    int                       checked;
    int                       degen_count;

    function new();
        threshold   = THRESH_RESET;
        errors      = 0;
        checked     = 0;
        degen_count = 0;
    endfunction

    // Round |n| * 16384 / sqrt(s), ties away from zero: largest k with (2k-1)^2 s <= (2^15 n)^2.
    function automatic logic [OUT_WIDTH-1:0] unit_q14(longint n, logic [139:0] s);
        logic [139:0]          m, lhs, rhs, odd;
        int unsigned           lo, hi, k;
        logic [OUT_WIDTH-1:0]  v;
        m   = (n < 0) ? 140'(-n) : 140'(n);
        lhs = (m << 15) * (m << 15);
        lo  = 0;
        hi  = 16384;
        while (lo < hi) begin
            k   = (lo + hi + 1) / 2;
            odd = 140'(2 * k - 1);
            rhs = odd * odd * s;
            if (lhs >= rhs) lo = k;
            else hi = k - 1;
        end
        v = lo[OUT_WIDTH-1:0];
        return (n < 0) ? -v : v;
    endfunction

    function automatic t_face_normal predict_normal(t_triangle t);
        longint        e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        logic [139:0]  mx, my, mz, s, tt;
        t_face_normal  r;
        e1x = longint'(t.bx) - longint'(t.ax);
        e1y = longint'(t.by) - longint'(t.ay);
        e1z = longint'(t.bz) - longint'(t.az);
        e2x = longint'(t.cx) - longint'(t.ax);
        e2y = longint'(t.cy) - longint'(t.ay);
        e2z = longint'(t.cz) - longint'(t.az);
        // Edges stay within 25 bits, so each cross term fits a longint exactly.
        nx = e1y * e2z - e1z * e2y;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        mx = (nx < 0) ? 140'(-nx) : 140'(nx);
        my = (ny < 0) ? 140'(-ny) : 140'(ny);
        mz = (nz < 0) ? 140'(-nz) : 140'(nz);
        s  = mx * mx + my * my + mz * mz;
        tt = 140'(threshold) * 140'(threshold);
        if (s > tt) begin
            r.nx    = unit_q14(nx, s);
            r.ny    = unit_q14(ny, s);
            r.nz    = unit_q14(nz, s);
            r.degen = 1'b0;
        end else begin
            r.nx    = Q14_ZERO;
            r.ny    = Q14_ONE;
            r.nz    = Q14_ZERO;
            r.degen = 1'b1;
        end
        return r;
    endfunction

    function void note_triangle(t_triangle t);
        expected_q.insert(expected_q.size(), predict_normal(t));
    endfunction

    function void check_normal(t_face_normal got);
        t_face_normal want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result nx=%0d ny=%0d nz=%0d degen=%0b",
                     $time, got.nx, got.ny, got.nz, got.degen);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (want.degen) degen_count++;
        if (got.nx !== want.nx) begin
            $display("%0t: normal_x expected %0d got %0d", $time, want.nx, got.nx);
            errors++;
        end
        if (got.ny !== want.ny) begin
            $display("%0t: normal_y expected %0d got %0d", $time, want.ny, got.ny);
            errors++;
        end
        if (got.nz !== want.nz) begin
            $display("%0t: normal_z expected %0d got %0d", $time, want.nz, got.nz);
            errors++;
        end
        if (got.degen !== want.degen) begin
            $display("%0t: degenerate expected %0b got %0b", $time, want.degen, got.degen);
            errors++;
        end
    endfunction
endclass

module triangle_face_normal_tb;

    localparam int PIPE_LAT   = 23;
    localparam int CYCLE_CAP  = 600000;
    localparam int PHASE_SIZE = 260;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic                         i_cfg_we;
    logic [THRESH_WIDTH-1:0]      i_cfg_wdata;
    t_triangle                    tri_in;
    logic                         o_valid;
    logic signed [OUT_WIDTH-1:0]  o_normal_x, o_normal_y, o_normal_z;
    logic                         o_degenerate;

    normal_scoreboard normals;
    int               cycle_count;
    int               sent_count;

    triangle_face_normal #(.COORD_WIDTH(24)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_first_x    (tri_in.ax),
        .i_first_y    (tri_in.ay),
        .i_first_z    (tri_in.az),
        .i_second_x   (tri_in.bx),
        .i_second_y   (tri_in.by),
        .i_second_z   (tri_in.bz),
        .i_third_x    (tri_in.cx),
        .i_third_y    (tri_in.cy),
        .i_third_z    (tri_in.cz),
        .o_valid      (o_valid),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_degenerate (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung pipeline or lost handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Predict each item on the edge that accepts it; check each strobe on the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) normals.note_triangle(tri_in);
        if (i_rst_n && o_valid) begin
            normals.check_normal('{nx: o_normal_x, ny: o_normal_y, nz: o_normal_z,
                                   degen: o_degenerate});
        end
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Call at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_triangle(t_triangle t);
        tri_in = t;
        start  = 1'b1;
        do @(posedge i_clk); while (busy);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            start = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Drain everything in flight, let the pipe empty, then write the threshold.
    task automatic write_threshold(logic [THRESH_WIDTH-1:0] value);
        start = 1'b0;
        while (normals.expected_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        normals.threshold = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = $urandom;
        @(negedge i_clk);
    endtask

    function automatic logic signed [23:0] near(logic signed [23:0] base, int span);
        return base + 24'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic signed [23:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return 24'sd0;
            3: return -24'sd1;
            default: return 24'sd1;
        endcase
    endfunction

    function automatic t_triangle random_triangle();
        t_triangle t;
        int        kind, k;
        logic signed [23:0] dx, dy, dz;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            // Full range: every coordinate bit toggles.
            {t.ax, t.ay, t.az} = {24'($urandom), 24'($urandom), 24'($urandom)};
            {t.bx, t.by, t.bz} = {24'($urandom), 24'($urandom), 24'($urandom)};
            {t.cx, t.cy, t.cz} = {24'($urandom), 24'($urandom), 24'($urandom)};
        end else if (kind < 60) begin
            // Small triangle somewhere in space, lengths around a few hundred LSB.
            t.ax = 24'($urandom) >>> 1; t.ay = 24'($urandom) >>> 1; t.az = 24'($urandom) >>> 1;
            t.bx = near(t.ax, 300); t.by = near(t.ay, 300); t.bz = near(t.az, 300);
            t.cx = near(t.ax, 300); t.cy = near(t.ay, 300); t.cz = near(t.az, 300);
        end else if (kind < 75) begin
            // Tiny triangle: normal length close to the threshold.
            t.ax = 24'($urandom); t.ay = 24'($urandom); t.az = 24'($urandom);
            t.bx = near(t.ax, 8); t.by = near(t.ay, 8); t.bz = near(t.az, 8);
            t.cx = near(t.ax, 8); t.cy = near(t.ay, 8); t.cz = near(t.az, 8);
        end else if (kind < 90) begin
            // Collinear corners: zero normal.
            t.ax = 24'($urandom) >>> 2; t.ay = 24'($urandom) >>> 2; t.az = 24'($urandom) >>> 2;
            dx = near(0, 1024); dy = near(0, 1024); dz = near(0, 1024);
            k  = $urandom_range(0, 100) - 50;
            t.bx = t.ax + dx; t.by = t.ay + dy; t.bz = t.az + dz;
            t.cx = t.ax + 24'(k) * dx; t.cy = t.ay + 24'(k) * dy; t.cz = t.az + 24'(k) * dz;
        end else begin
            t.ax = pick_extreme(); t.ay = pick_extreme(); t.az = pick_extreme();
            t.bx = pick_extreme(); t.by = pick_extreme(); t.bz = pick_extreme();
            t.cx = pick_extreme(); t.cy = pick_extreme(); t.cz = pick_extreme();
        end
        return t;
    endfunction

    task automatic run_random(int count);
        repeat (count) begin
            send_triangle(random_triangle());
            idle_cycles(draw_gap());
        end
    endtask

    task automatic run_directed();
        t_triangle d[$];
        d.insert(d.size(), '{0, 0, 0, 0, 0, 0, 0, 0, 0});
        d.insert(d.size(), '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                             24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF});
        d.insert(d.size(), '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000,
                             24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000});
        // Largest edges the fields allow, in both signs.
        d.insert(d.size(), '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                             24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh800000});
        d.insert(d.size(), '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                             24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000});
        d.insert(d.size(), '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                             24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF});
        // Unit right triangles: normal along +z, -z, +x and +y.
        d.insert(d.size(), '{0, 0, 0, 4096, 0, 0, 0, 4096, 0});
        d.insert(d.size(), '{0, 0, 0, 0, 4096, 0, 4096, 0, 0});
        d.insert(d.size(), '{0, 0, 0, 0, 4096, 0, 0, 0, 4096});
        d.insert(d.size(), '{0, 0, 0, 0, 0, 4096, 4096, 0, 0});
        // Normal length exactly at the reset threshold, then just above it, then below it.
        d.insert(d.size(), '{0, 0, 0, 1, 0, 0, 0, 2, 0});
        d.insert(d.size(), '{0, 0, 0, 1, 0, 0, 0, 3, 0});
        d.insert(d.size(), '{5, 5, 5, 6, 5, 5, 5, 5, 6});
        // Diagonal normal: all three components equal.
        d.insert(d.size(), '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096});
        // Collinear and repeated corners.
        d.insert(d.size(), '{100, 200, 300, 200, 400, 600, 300, 600, 900});
        d.insert(d.size(), '{-7, 9, -11, -7, 9, -11, 40, -3, 2});
        foreach (d[i]) begin
            send_triangle(d[i]);
            idle_cycles(i % 3);
        end
    endtask

    initial begin
        logic [THRESH_WIDTH-1:0] settings[$];
        normals     = new();
        cycle_count = 0;
        sent_count  = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        tri_in      = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset threshold first, then the extremes and a few others.
        run_directed();
        run_random(PHASE_SIZE);
        settings = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(3, 64)), 16'd300,
                     16'($urandom)};
        foreach (settings[i]) begin
            write_threshold(settings[i]);
            if (settings[i] == 16'd0) run_directed();
            run_random(PHASE_SIZE);
        end

        start = 1'b0;
        while (normals.expected_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 8) @(negedge i_clk);

        $display("Sent %0d triangles over %0d threshold settings; %0d normals checked",
                 sent_count, settings.size() + 1, normals.checked);
        $display("%0d of them fell back to the up vector", normals.degen_count);
        if (normals.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
